// ----- sv/mpht_pkg.sv -----
// mpht_pkg: request/response payload types, command codes and the
// controller/datapath command and status structs. No dependencies.
package mpht_pkg;

   localparam int COORD_W = 16;
   localparam int HIT_W   = 4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                      command;
      logic [2:0]                poly_index;
      logic [3:0]                vertex_index;
      logic                      last_vertex;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic             inside_res;
      logic [HIT_W-1:0] hit_polygon;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic wr_en;         // store vertex of the accepted write request
      logic load_query;    // latch query point
      logic clear_parity;  // start of a polygon walk
      logic rd_first;      // read closing vertex (n-1) into the edge start
      logic rd_edge;       // read vertex i, evaluate edge (i-1 -> i)
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic parity;
   } dp_stat_type;

endpackage

// ----- sv/multi_polygon_point_hit_test.sv -----
// multi_polygon_point_hit_test: top level, even-odd point-in-polygon test
// over stored polygons. Depends on mpht_pkg, mpht_ctrl, mpht_datapath.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_data  (mpht_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready   rsp_data  (mpht_pkg::rsp_type)
//
// A query walks the polygons in order, skipping empty ones; the walk stops at
// the first containing polygon. One vertex memory read per edge.
// Reset empties all polygons; vertex memory contents are undefined until written.
// req_ready is low while a query runs; the result waits in an output register,
// and a finished query holds until that register is free.
module multi_polygon_point_hit_test #(
   parameter int MAX_POLYGONS = 8,
   parameter int MAX_VERTICES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpht_pkg::rsp_type rsp_data
);

   localparam int PW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   mpht_pkg::dp_cmd_type  cmd;
   mpht_pkg::dp_stat_type stat;
   logic [PW-1:0]         rd_poly;
   logic [VW-1:0]         rd_vert;
   logic [CW-1:0]         count;

   mpht_ctrl #(
      .MAX_POLYGONS(MAX_POLYGONS),
      .PW(PW),
      .VW(VW),
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .cmd(cmd),
      .rd_poly(rd_poly),
      .rd_vert(rd_vert),
      .count(count),
      .stat(stat)
   );

   mpht_datapath #(
      .MAX_POLYGONS(MAX_POLYGONS),
      .MAX_VERTICES(MAX_VERTICES),
      .PW(PW),
      .VW(VW),
      .CW(CW)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .rd_poly(rd_poly),
      .rd_vert(rd_vert),
      .count(count),
      .stat(stat)
   );

endmodule

// ----- sv/mpht_datapath.sv -----
// mpht_datapath: vertex memory, vertex counts, query point and the
// 4-stage edge crossing pipeline (read, diffs, products, compare/parity).
// Depends on mpht_pkg.
module mpht_datapath #(
   parameter int MAX_POLYGONS = 8,
   parameter int MAX_VERTICES = 16,
   parameter int PW = 3,
   parameter int VW = 4,
   parameter int CW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpht_pkg::req_type     req_data,
   input  mpht_pkg::dp_cmd_type  cmd,
   input  logic [PW-1:0]         rd_poly,
   input  logic [VW-1:0]         rd_vert,
   output logic [CW-1:0]         count,
   output mpht_pkg::dp_stat_type stat
);

   localparam int DEPTH = MAX_POLYGONS * MAX_VERTICES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CRW   = mpht_pkg::COORD_W;
   localparam int DW    = 2 * CRW;
   localparam int DFW   = CRW + 1;
   localparam int PRW   = 2 * DFW;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [CW-1:0] counts_ff [MAX_POLYGONS];
   logic [CW-1:0] counts_in [MAX_POLYGONS];

   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          wr_ok;

   logic signed [CRW-1:0] qx_ff, qz_ff;
   logic signed [CRW-1:0] xi, zi, xj_ff, zj_ff;

   logic                  v1_first_ff, v1_edge_ff, v2_ff, v3_ff;
   logic signed [DFW-1:0] dxq_ff, dz_ff, dxj_ff, dzq_ff;
   logic                  strad2_ff, dzpos2_ff, strad3_ff, dzpos3_ff;
   logic signed [PRW-1:0] lhs_ff, rhs_ff;
   logic                  parity_ff, parity_in, crossed;

   assign wr_ok = (32'(req_data.poly_index) < MAX_POLYGONS) &&
                  (32'(req_data.vertex_index) < MAX_VERTICES);
   assign wr_addr = AW'(AW'(PW'(req_data.poly_index)) * AW'(MAX_VERTICES)) +
                    AW'(VW'(req_data.vertex_index));
   assign rd_addr = AW'(AW'(rd_poly) * AW'(MAX_VERTICES)) + AW'(rd_vert);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem[wr_addr] <= {req_data.coord_x, req_data.coord_z};
      end
      if (cmd.rd_first || cmd.rd_edge) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      counts_in = counts_ff;
      if (cmd.wr_en && wr_ok && req_data.last_vertex) begin
         counts_in[PW'(req_data.poly_index)] = CW'(32'(req_data.vertex_index) + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_POLYGONS; p++) begin
            counts_ff[p] <= '0;
         end
      end else begin
         counts_ff <= counts_in;
      end
   end

   assign count = counts_ff[rd_poly];

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qx_ff <= req_data.coord_x;
         qz_ff <= req_data.coord_z;
      end
   end

   assign xi = rd_data_ff[DW-1:CRW];
   assign zi = rd_data_ff[CRW-1:0];

   // stage 1: edge start register and differences
   always_ff @(posedge clock) begin
      if (v1_first_ff || v1_edge_ff) begin
         xj_ff <= xi;
         zj_ff <= zi;
      end
      if (v1_edge_ff) begin
         dxq_ff    <= DFW'(qx_ff) - DFW'(xi);
         dz_ff     <= DFW'(zj_ff) - DFW'(zi);
         dxj_ff    <= DFW'(xj_ff) - DFW'(xi);
         dzq_ff    <= DFW'(qz_ff) - DFW'(zi);
         strad2_ff <= (zi > qz_ff) != (zj_ff > qz_ff);
         dzpos2_ff <= zj_ff > zi;
      end
   end

   // stage 2: cross products
   always_ff @(posedge clock) begin
      if (v2_ff) begin
         lhs_ff    <= dxq_ff * dz_ff;
         rhs_ff    <= dxj_ff * dzq_ff;
         strad3_ff <= strad2_ff;
         dzpos3_ff <= dzpos2_ff;
      end
   end

   // stage 3: exact intersection compare
   assign crossed = strad3_ff && (dzpos3_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

   always_comb begin
      parity_in = parity_ff;
      if (cmd.clear_parity) begin
         parity_in = 1'b0;
      end else if (v3_ff && crossed) begin
         parity_in = !parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_first_ff <= 1'b0;
         v1_edge_ff  <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         v1_first_ff <= cmd.rd_first;
         v1_edge_ff  <= cmd.rd_edge;
         v2_ff       <= v1_edge_ff;
         v3_ff       <= v2_ff;
         parity_ff   <= parity_in;
      end
   end

   assign stat.parity = parity_ff;

endmodule

// ----- sv/mpht_ctrl.sv -----
// mpht_ctrl: request handshake, polygon/vertex sequencing state machine
// and the response output register. Depends on mpht_pkg.
module mpht_ctrl #(
   parameter int MAX_POLYGONS = 8,
   parameter int PW = 3,
   parameter int VW = 4,
   parameter int CW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mpht_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mpht_pkg::rsp_type     rsp_data,
   output mpht_pkg::dp_cmd_type  cmd,
   output logic [PW-1:0]         rd_poly,
   output logic [VW-1:0]         rd_vert,
   input  logic [CW-1:0]         count,
   input  mpht_pkg::dp_stat_type stat
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_EDGES  = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   localparam logic [1:0] DRAIN_LAST = 2'd3;

   state_type         state_ff, state_in;
   logic [PW-1:0]     poly_ff, poly_in;
   logic [VW-1:0]     vert_ff, vert_in;
   logic [1:0]        drain_ff, drain_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mpht_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              req_acc;
   logic              last_poly;
   logic [VW-1:0]     vert_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign last_poly = (poly_ff == PW'(MAX_POLYGONS - 1));
   assign vert_last = VW'(count - CW'(1));

   always_comb begin
      state_in     = state_ff;
      poly_in      = poly_ff;
      vert_in      = vert_ff;
      drain_in     = drain_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      rd_poly      = poly_ff;
      rd_vert      = vert_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.command == mpht_pkg::CMD_QUERY) begin
                  cmd.load_query = 1'b1;
                  poly_in        = '0;
                  found_in       = 1'b0;
                  state_in       = ST_LOOKUP;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_LOOKUP: begin
            cmd.clear_parity = 1'b1;
            if (count == '0) begin
               if (last_poly) begin
                  state_in = ST_RESULT;
               end else begin
                  poly_in = poly_ff + PW'(1);
               end
            end else begin
               cmd.rd_first = 1'b1;
               rd_vert      = vert_last;
               vert_in      = '0;
               state_in     = ST_EDGES;
            end
         end
         ST_EDGES: begin
            cmd.rd_edge = 1'b1;
            if (vert_ff == vert_last) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               vert_in = vert_ff + VW'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               if (stat.parity) begin
                  found_in = 1'b1;
                  state_in = ST_RESULT;
               end else if (last_poly) begin
                  state_in = ST_RESULT;
               end else begin
                  poly_in  = poly_ff + PW'(1);
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.inside_res = found_ff;
               rsp_data_in.hit_polygon = found_ff ? mpht_pkg::HIT_W'(poly_ff)
                                                  : mpht_pkg::HIT_W'(MAX_POLYGONS);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      poly_ff     <= poly_in;
      vert_ff     <= vert_in;
      drain_ff    <= drain_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/mpht_checker.sv -----
// mpht_checker: port-level assertions for multi_polygon_point_hit_test,
// bound to the top level. Depends on mpht_pkg.
module mpht_checker #(
   parameter int MAX_POLYGONS = 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mpht_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mpht_pkg::rsp_type rsp_data
);

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (MAX_POLYGONS < 16) |->
         rsp_data.inside_res ==
            (rsp_data.hit_polygon != mpht_pkg::HIT_W'(MAX_POLYGONS)))
      else $error("inside flag disagrees with hit index");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == mpht_pkg::CMD_WRITE)
         && !rsp_valid |=> !rsp_valid)
      else $error("vertex write produced a response");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == mpht_pkg::CMD_QUERY)
         |=> !req_ready)
      else $error("request taken during a query");

endmodule

bind multi_polygon_point_hit_test mpht_checker #(
   .MAX_POLYGONS(MAX_POLYGONS)
) u_mpht_checker (.*);
